/* hdl/npcm_pkg.sv */
// shared types and constants for the nearest palette color match block
// no dependencies; imported by npcm_palette, nearest_palette_color_match, npcm_match_checker and the testbench top
package npcm_pkg;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int DIST_W  = 28;
  localparam int SQ_W    = 16;
  localparam int WEIGHT_W = 10;
  localparam int PROD_W  = 26;

  // palette sizing
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int INDEX_REACH       = 256;

  // redmean weight bases, scaled by 256
  localparam logic [WEIGHT_W-1:0] RED_WEIGHT_BASE  = 10'd512;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_BASE = 10'd767;
  localparam int GREEN_SHIFT = 10;

  // upper bound on the distance the block can report
  localparam logic [DIST_W-1:0] MAX_DIST = 28'd166333950;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // palette write request
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    rgb_t               color;
  } pal_wr_t;

  // scan sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DIFF,
    S_SQ_R,
    S_WT_R,
    S_SQ_G,
    S_SQ_B,
    S_WT_B,
    S_CMP,
    S_DONE
  } state_t;

endpackage

/* hdl/npcm_palette.sv */
// palette color memory: one write port with range check, one registered read port
// depends on npcm_pkg
module npcm_palette
  import npcm_pkg::*;
#(
  parameter int DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  pal_wr_t                    wr,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output rgb_t                       rd_data
);

  localparam int AW = $clog2(DEPTH);

  rgb_t            mem [DEPTH];
  logic [AW-1:0]   wr_addr;
  logic            wr_in_range;

  // loads beyond the palette depth are dropped
  assign wr_in_range = (32'(wr.index) < 32'(DEPTH));

  generate
    if (AW >= INDEX_W) begin : g_wide
      assign wr_addr = AW'(wr.index);
    end else begin : g_narrow
      assign wr_addr = wr.index[AW-1:0];
    end
  endgenerate

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= wr.color;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/nearest_palette_color_match.sv */
// Nearest palette color match, redmean distance. A load item (opcode 0) writes one
// palette entry and gives no result. A match item (opcode 1) scans entries 0 .. n-1,
// n being entry_count limited to the palette depth and to 256, and returns the index,
// color and scaled distance (512+rAvg)dR^2 + 1024dG^2 + (767-rAvg)dB^2 of the nearest
// entry, the earliest one on a tie; with n = 0 it returns status 1 and zeros. In a
// match each entry costs one registered palette read, a difference step, five passes
// through the one shared 10x16 multiplier (three squares and two weightings) and a
// compare. in_stall is high for the whole scan. Entries a match reads must have been
// loaded since reset.
// depends on npcm_pkg and npcm_palette
module nearest_palette_color_match
  import npcm_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [CHAN_W-1:0]   red,
  input  logic [CHAN_W-1:0]   green,
  input  logic [CHAN_W-1:0]   blue,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  match_index,
  output logic [CHAN_W-1:0]   match_red,
  output logic [CHAN_W-1:0]   match_green,
  output logic [CHAN_W-1:0]   match_blue,
  output logic [DIST_W-1:0]   best_distance,
  output logic                status
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int LIMIT = (PALETTE_DEPTH < INDEX_REACH) ? PALETTE_DEPTH : INDEX_REACH;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   entry_count;
  logic [COUNT_W-1:0]   n;
  logic [COUNT_W-1:0]   n_eff;
  logic                 empty;
  rgb_t                 pix;
  rgb_t                 cur;
  rgb_t                 rd_data;
  logic [AW-1:0]        rd_addr;
  pal_wr_t              pal_wr;
  logic [INDEX_W-1:0]   scan_idx;
  logic [CHAN_W-1:0]    dr, dg, db, ravg;
  logic [PROD_W-1:0]    prod;
  logic [DIST_W-1:0]    acc;
  logic [DIST_W-1:0]    entry_dist;
  logic [DIST_W-1:0]    best_d;
  logic [INDEX_W-1:0]   best_idx;
  rgb_t                 best_rgb;
  logic [WEIGHT_W-1:0]  mul_a;
  logic [SQ_W-1:0]      mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 prod_load;
  logic                 in_accept;
  logic                 out_accept;
  logic                 out_free;
  logic                 last;

  // handshakes
  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;

  // effective entry count
  assign n_eff      = (entry_count > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : entry_count;
  assign last       = (({1'b0, scan_idx} + 9'd1) == n);
  assign entry_dist = acc + DIST_W'(prod);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  // palette memory
  assign pal_wr.en    = in_accept && (opcode == OP_LOAD);
  assign pal_wr.index = entry_index;
  assign pal_wr.color = '{r: red, g: green, b: blue};

  generate
    if (AW >= INDEX_W) begin : g_addr_wide
      assign rd_addr = AW'(scan_idx);
    end else begin : g_addr_narrow
      assign rd_addr = scan_idx[AW-1:0];
    end
  endgenerate

  npcm_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr      (pal_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && (opcode == OP_MATCH)) begin
          state_next = (n_eff == '0) ? S_DONE : S_FETCH;
        end
      end
      S_FETCH: state_next = S_DIFF;
      S_DIFF:  state_next = S_SQ_R;
      S_SQ_R:  state_next = S_WT_R;
      S_WT_R:  state_next = S_SQ_G;
      S_SQ_G:  state_next = S_SQ_B;
      S_SQ_B:  state_next = S_WT_B;
      S_WT_B:  state_next = S_CMP;
      S_CMP:   state_next = last ? S_DONE : S_FETCH;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    prod_load = 1'b0;
    case (state)
      S_SQ_R: begin
        mul_a     = WEIGHT_W'(dr);
        mul_b     = SQ_W'(dr);
        prod_load = 1'b1;
      end
      S_WT_R: begin
        mul_a     = RED_WEIGHT_BASE + WEIGHT_W'(ravg);
        mul_b     = prod[SQ_W-1:0];
        prod_load = 1'b1;
      end
      S_SQ_G: begin
        mul_a     = WEIGHT_W'(dg);
        mul_b     = SQ_W'(dg);
        prod_load = 1'b1;
      end
      S_SQ_B: begin
        mul_a     = WEIGHT_W'(db);
        mul_b     = SQ_W'(db);
        prod_load = 1'b1;
      end
      S_WT_B: begin
        mul_a     = BLUE_WEIGHT_BASE - WEIGHT_W'(ravg);
        mul_b     = prod[SQ_W-1:0];
        prod_load = 1'b1;
      end
      default: begin
        prod_load = 1'b0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (prod_load) begin
      prod <= mul_p;
    end
    case (state)
      S_IDLE: begin
        if (in_accept && (opcode == OP_MATCH)) begin
          pix      <= '{r: red, g: green, b: blue};
          n        <= n_eff;
          empty    <= (n_eff == '0);
          scan_idx <= '0;
        end
      end
      S_DIFF: begin
        cur  <= rd_data;
        dr   <= (rd_data.r > pix.r) ? rd_data.r - pix.r : pix.r - rd_data.r;
        dg   <= (rd_data.g > pix.g) ? rd_data.g - pix.g : pix.g - rd_data.g;
        db   <= (rd_data.b > pix.b) ? rd_data.b - pix.b : pix.b - rd_data.b;
        ravg <= CHAN_W'(({1'b0, rd_data.r} + {1'b0, pix.r}) >> 1);
      end
      S_SQ_G: begin
        acc <= DIST_W'(prod);
      end
      S_SQ_B: begin
        acc <= acc + DIST_W'({prod[SQ_W-1:0], {GREEN_SHIFT{1'b0}}});
      end
      S_CMP: begin
        // strict compare keeps the earliest entry on a tie
        if ((scan_idx == '0) || (entry_dist < best_d)) begin
          best_d   <= entry_dist;
          best_idx <= scan_idx;
          best_rgb <= cur;
        end
        scan_idx <= scan_idx + 8'd1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      if (empty) begin
        match_index   <= '0;
        match_red     <= '0;
        match_green   <= '0;
        match_blue    <= '0;
        best_distance <= '0;
        status        <= STATUS_EMPTY;
      end else begin
        match_index   <= best_idx;
        match_red     <= best_rgb.r;
        match_green   <= best_rgb.g;
        match_blue    <= best_rgb.b;
        best_distance <= best_d;
        status        <= STATUS_OK;
      end
    end
  end

`ifndef ASSERT_OFF
  // scan never reads past the effective count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIFF) || (state == S_CMP)) |-> ({1'b0, scan_idx} < n))
    else $error("scan index beyond entry count");

  // a match item always starts the sequencer
  a_match_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (opcode == OP_MATCH)) |=> (state != S_IDLE))
    else $error("match item did not start a scan");

  // reported distance stays within the redmean range
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (best_distance <= MAX_DIST))
    else $error("distance out of range");

  // empty palette result carries zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_EMPTY)) |-> ((match_index == '0) && (best_distance == '0)))
    else $error("empty result not cleared");
`endif

endmodule

/* tb/sv/npcm_match_checker.sv */
// checker for nearest_palette_color_match: mirrors the palette and entry count,
// predicts each match result and compares the results in order
// depends on npcm_pkg
module npcm_match_checker
  import npcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [INDEX_W-1:0] match_index,
  input  logic [CHAN_W-1:0]  match_red,
  input  logic [CHAN_W-1:0]  match_green,
  input  logic [CHAN_W-1:0]  match_blue,
  input  logic [DIST_W-1:0]  best_distance,
  input  logic               status,
  output int                 fail_count,
  output int                 hits_pending,
  output int                 loads_seen,
  output int                 results_checked,
  output int                 empty_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    rgb_t               color;
    logic [DIST_W-1:0]  distance;
    logic               status;
  } palette_hit_t;

  rgb_t               palette_mirror [PALETTE_DEPTH_DEF];
  logic [COUNT_W-1:0] scan_count;
  palette_hit_t       expected_hits [$];

  // scaled squared redmean distance between a palette entry and a pixel
  function automatic int unsigned redmean_cost(rgb_t entry, rgb_t pixel);
    int unsigned er, eg, eb, pr, pg, pb, ravg, dr, dg, db;
    er = entry.r; eg = entry.g; eb = entry.b;
    pr = pixel.r; pg = pixel.g; pb = pixel.b;
    ravg = (er + pr) >> 1;
    dr = (er > pr) ? er - pr : pr - er;
    dg = (eg > pg) ? eg - pg : pg - eg;
    db = (eb > pb) ? eb - pb : pb - eb;
    return (int'(RED_WEIGHT_BASE) + ravg) * dr * dr + (1 << GREEN_SHIFT) * dg * dg
         + (int'(BLUE_WEIGHT_BASE) - ravg) * db * db;
  endfunction

  // scan the active entries, earliest entry wins a tie
  function automatic palette_hit_t nearest_entry(rgb_t pixel);
    palette_hit_t hit;
    int span, best, k;
    int unsigned cost, best_cost;
    hit = '0;
    span = int'(scan_count);
    if (span > PALETTE_DEPTH_DEF) span = PALETTE_DEPTH_DEF;
    if (span > INDEX_REACH) span = INDEX_REACH;
    if (span == 0) begin
      hit.status = STATUS_EMPTY;
      return hit;
    end
    best = 0;
    best_cost = redmean_cost(palette_mirror[0], pixel);
    for (k = 1; k < span; k++) begin
      cost = redmean_cost(palette_mirror[k], pixel);
      if (cost < best_cost) begin
        best_cost = cost;
        best = k;
      end
    end
    hit.index    = INDEX_W'(best);
    hit.color    = palette_mirror[best];
    hit.distance = DIST_W'(best_cost);
    hit.status   = STATUS_OK;
    return hit;
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // watch config, input items and result items at each rising edge
  always @(posedge clk) begin : watch
    palette_hit_t seen, want;
    if (rst) begin
      expected_hits.delete();
      scan_count = '0;
      fail_count = 0;
      loads_seen = 0;
      results_checked = 0;
      empty_results = 0;
    end else begin
      if (cfg_wr_en) scan_count = cfg_wr_data;
      // accepted input item
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          if (entry_index < PALETTE_DEPTH_DEF) palette_mirror[entry_index] = {red, green, blue};
          loads_seen++;
        end else begin
          expected_hits.insert(expected_hits.size(), nearest_entry({red, green, blue}));
        end
      end
      // accepted result item
      if (out_valid && !out_stall) begin
        seen.index    = match_index;
        seen.color    = {match_red, match_green, match_blue};
        seen.distance = best_distance;
        seen.status   = status;
        if (expected_hits.size() == 0) begin
          log_failure($sformatf("result with nothing expected: index %0d rgb %0d,%0d,%0d dist %0d status %0d",
            seen.index, seen.color.r, seen.color.g, seen.color.b, seen.distance, seen.status));
        end else begin
          want = expected_hits.pop_front();
          results_checked++;
          if (want.status == STATUS_EMPTY) empty_results++;
          if (seen.index !== want.index || seen.color.r !== want.color.r ||
              seen.color.g !== want.color.g || seen.color.b !== want.color.b ||
              seen.distance !== want.distance || seen.status !== want.status) begin
            log_failure($sformatf(
              "mismatch: expected index %0d rgb %0d,%0d,%0d dist %0d status %0d, got index %0d rgb %0d,%0d,%0d dist %0d status %0d",
              want.index, want.color.r, want.color.g, want.color.b, want.distance, want.status,
              seen.index, seen.color.r, seen.color.g, seen.color.b, seen.distance, seen.status));
          end
        end
      end
    end
    hits_pending = expected_hits.size();
  end

endmodule

/* tb/sv/nearest_palette_color_match_tb.sv */
// top of the nearest_palette_color_match testbench: clock, reset, stimulus, verdict
// depends on npcm_pkg, nearest_palette_color_match and npcm_match_checker
module nearest_palette_color_match_tb
  import npcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int RESET_CYCLES   = 12;
  localparam int HEAVY_IDLE_PCT = 71;
  localparam int LIGHT_IDLE_PCT = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int MATCH_PCT      = 60;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  red, green, blue;
  logic               out_valid;
  logic               out_stall;
  logic [INDEX_W-1:0] match_index;
  logic [CHAN_W-1:0]  match_red, match_green, match_blue;
  logic [DIST_W-1:0]  best_distance;
  logic               status;

  int chk_failures, chk_pending, chk_loads, chk_results, chk_empty;

  idle_mode_t idle_mode = IDLE_NONE;
  int         hold_requests = 0;
  int         scan_span = 0;
  rgb_t       palette_shadow [INDEX_REACH];

  nearest_palette_color_match i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .match_index   (match_index),
    .match_red     (match_red),
    .match_green   (match_green),
    .match_blue    (match_blue),
    .best_distance (best_distance),
    .status        (status)
  );

  npcm_match_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .entry_index     (entry_index),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .match_index     (match_index),
    .match_red       (match_red),
    .match_green     (match_green),
    .match_blue      (match_blue),
    .best_distance   (best_distance),
    .status          (status),
    .fail_count      (chk_failures),
    .hits_pending    (chk_pending),
    .loads_seen      (chk_loads),
    .results_checked (chk_results),
    .empty_results   (chk_empty)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still due", TIMEOUT_CYCLES, chk_pending);
    $display("nearest_palette_color_match test failed");
    $finish;
  end

  // result side stall, with a long hold-off on request
  initial begin : receiver
    int hold_seen, hold_left, pct;
    out_stall = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: pct = HEAVY_IDLE_PCT;
          IDLE_BOTH:     pct = LIGHT_IDLE_PCT;
          default:       pct = 0;
        endcase
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  function automatic rgb_t random_color();
    return {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  // pixel for a match: random, near or on an active entry, a corner, or between two entries
  function automatic rgb_t pick_pixel();
    int sel;
    rgb_t base, other, pixel;
    sel = $urandom_range(9);
    if (scan_span == 0 || sel < 4) return random_color();
    base  = palette_shadow[$urandom_range(scan_span - 1)];
    other = palette_shadow[$urandom_range(scan_span - 1)];
    case (sel)
      7: pixel = base;
      8: pixel = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                  {8{1'($urandom_range(1))}}};
      9: pixel = {8'((int'(base.r) + int'(other.r)) / 2), 8'((int'(base.g) + int'(other.g)) / 2),
                  8'((int'(base.b) + int'(other.b)) / 2)};
      default: pixel = {nudge(base.r, 6), nudge(base.g, 6), nudge(base.b, 6)};
    endcase
    return pixel;
  endfunction

  // offer one item after a random gap, return at the falling edge after acceptance
  task automatic send_item(logic op, logic [INDEX_W-1:0] idx, rgb_t color);
    int pct, gap;
    case (idle_mode)
      IDLE_SENDER: pct = HEAVY_IDLE_PCT;
      IDLE_BOTH:   pct = LIGHT_IDLE_PCT;
      default:     pct = 0;
    endcase
    gap = 0;
    while ($urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    red         <= color.r;
    green       <= color.g;
    blue        <= color.b;
    if (op == OP_LOAD) palette_shadow[idx] = color;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid and wait until every match result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(int value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[COUNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    scan_span = (value > INDEX_REACH) ? INDEX_REACH : value;
  endtask

  // one setting of the entry count with a random mix of loads and matches
  task automatic run_phase(int count, idle_mode_t mode, int items);
    rgb_t color;
    write_count(count);
    idle_mode = mode;
    repeat (items) begin
      if ($urandom_range(99) < MATCH_PCT) begin
        send_item(OP_MATCH, 8'($urandom_range(255)), pick_pixel());
      end else begin
        // some loads copy another entry so that ties come up
        color = ($urandom_range(4) == 0) ? palette_shadow[$urandom_range(255)] : random_color();
        send_item(OP_LOAD, 8'($urandom_range(255)), color);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    int i;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    opcode      = OP_LOAD;
    entry_index = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty palette
    write_count(0);
    send_item(OP_MATCH, 8'd0, {8'd10, 8'd20, 8'd30});

    // corner colors, a duplicate of entry 0 for a tie, and the top index
    send_item(OP_LOAD, 8'd0, {8'd0, 8'd0, 8'd0});
    send_item(OP_LOAD, 8'd1, {8'd255, 8'd255, 8'd255});
    send_item(OP_LOAD, 8'd2, {8'd255, 8'd0, 8'd0});
    send_item(OP_LOAD, 8'd3, {8'd0, 8'd255, 8'd0});
    send_item(OP_LOAD, 8'd4, {8'd0, 8'd0, 8'd255});
    send_item(OP_LOAD, 8'd5, {8'd0, 8'd0, 8'd0});
    send_item(OP_LOAD, 8'd255, {8'd128, 8'd128, 8'd128});

    // single entry: largest and zero distance
    write_count(1);
    send_item(OP_MATCH, 8'd255, {8'd255, 8'd255, 8'd255});
    send_item(OP_MATCH, 8'd0, {8'd0, 8'd0, 8'd0});

    // six entries, tie between entries 0 and 5
    write_count(6);
    send_item(OP_MATCH, 8'd0, {8'd0, 8'd0, 8'd0});
    send_item(OP_MATCH, 8'd0, {8'd250, 8'd250, 8'd250});
    send_item(OP_MATCH, 8'd0, {8'd250, 8'd5, 8'd5});
    send_item(OP_MATCH, 8'd0, {8'd5, 8'd250, 8'd5});
    send_item(OP_MATCH, 8'd0, {8'd5, 8'd5, 8'd250});

    // fill the whole palette so any count is safe to scan
    settle();
    idle_mode = IDLE_SENDER;
    for (i = 0; i < INDEX_REACH; i++) send_item(OP_LOAD, i[INDEX_W-1:0], random_color());

    // random phases over counts and idle mixes
    run_phase(256, IDLE_NONE, 6);
    run_phase(1, IDLE_RECEIVER, 25);
    run_phase(0, IDLE_SENDER, 10);
    run_phase(12, IDLE_BOTH, 30);
    run_phase(40, IDLE_RECEIVER, 25);
    run_phase(3, IDLE_SENDER, 25);
    run_phase(255, IDLE_BOTH, 5);
    run_phase(511, IDLE_NONE, 4);
    run_phase($urandom_range(2, 32), IDLE_NONE, 30);
    run_phase($urandom_range(4, 64), IDLE_RECEIVER, 25);

    // long output hold-off while matches keep coming
    write_count(4);
    idle_mode = IDLE_NONE;
    hold_requests++;
    repeat (12) send_item(OP_MATCH, 8'($urandom_range(255)), pick_pixel());

    // drain and verdict
    settle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d loads and %0d checked matches, %0d of them on an empty palette,",
             chk_loads, chk_results, chk_empty);
    $display("entry counts 0 to 511, four idle mixes and one long output hold-off");
    if (chk_failures + chk_pending == 0) begin
      $display("nearest_palette_color_match test passed");
    end else begin
      $display("%0d failures, %0d results never arrived", chk_failures, chk_pending);
      $display("nearest_palette_color_match test failed");
    end
    $finish;
  end

endmodule
